FILE: rtl/rrps_pkg.sv
// types and constants shared by the rounded rectangle pixel shader
// no dependencies; compiled before the interfaces and modules
package rrps_pkg;

    localparam int MAX_DIM    = 2048;

    localparam int PIX_W      = 11;
    localparam int DIM_W      = 12;
    localparam int RAD_W      = 11;
    localparam int COLOR_W    = 32;
    localparam int PITCH_W    = 13;
    localparam int ADDR_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIST_W     = 12;
    localparam int SQ_W       = 2 * DIST_W + 1;
    localparam int RSQ_W      = 2 * RAD_W;

    localparam logic [COLOR_W-1:0] DARKEN_MASK = 32'h00FE_FEFE;
    localparam logic [COLOR_W-1:0] TRANSPARENT = 32'h0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_COLOR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSED_MODE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]   box_width;
        logic [DIM_W-1:0]   box_height;
        logic [RAD_W-1:0]   corner_radius;
        logic [RAD_W-1:0]   border_width;
        logic [COLOR_W-1:0] fill_color;
        logic [COLOR_W-1:0] edge_color;
        logic               pressed_mode;
        logic [PITCH_W-1:0] row_pitch;
    } cfg_regs_t;

    typedef struct packed {
        logic              in_box;
        logic              band;
        logic [DIST_W-1:0] dx;
        logic [DIST_W-1:0] dy;
        logic [RAD_W-1:0]  inner_mag;
        logic [PIX_W-1:0]  x;
        logic [PIX_W-1:0]  y;
    } geom_t;

    typedef struct packed {
        logic              in_box;
        logic              band;
        logic [SQ_W-1:0]   d2;
        logic [RSQ_W-1:0]  r2;
        logic [RSQ_W-1:0]  inner2;
        logic [ADDR_W-1:0] prod;
        logic [PIX_W-1:0]  x;
    } sq_t;

endpackage

FILE: rtl/rrps_if.sv
// channel interfaces: pixel coordinates in, shaded pixel out, register writes
// depends on rrps_pkg for field widths
interface rrps_pix_in_if import rrps_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pix_x;
    logic [PIX_W-1:0] pix_y;

    modport source (output valid, output pix_x, output pix_y, input ready);
    modport sink (input valid, input pix_x, input pix_y, output ready);
endinterface

interface rrps_pix_out_if import rrps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_value;
    logic [ADDR_W-1:0]  pixel_addr;

    modport source (output valid, output pixel_value, output pixel_addr, input ready);
    modport sink (input valid, input pixel_value, input pixel_addr, output ready);
endinterface

interface rrps_cfg_if import rrps_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/rrps_corner_sel.sv
// corner box selection, corner distances and straight border band test
// depends on rrps_pkg
module rrps_corner_sel import rrps_pkg::*;
(
    input  cfg_regs_t        cfg,
    input  logic [PIX_W-1:0] x,
    input  logic [PIX_W-1:0] y,
    output geom_t            geom
);

    logic [DIM_W:0]    x_ext;
    logic [DIM_W:0]    y_ext;
    logic [DIM_W:0]    r_ext;
    logic [DIM_W:0]    b_ext;
    logic              xl;
    logic              xr;
    logic              yt;
    logic              yb;
    logic [DIM_W:0]    dx_left;
    logic [DIM_W:0]    dx_right;
    logic [DIM_W:0]    dy_top;
    logic [DIM_W:0]    dy_bot;
    logic              near_edge;

    always_comb
    begin
        x_ext = {2'b00, x};
        y_ext = {2'b00, y};
        r_ext = {2'b00, cfg.corner_radius};
        b_ext = {2'b00, cfg.border_width};

        xl = x_ext < r_ext;
        xr = (x_ext + r_ext) >= {1'b0, cfg.box_width};
        yt = y_ext < r_ext;
        yb = (y_ext + r_ext) >= {1'b0, cfg.box_height};

        // far-edge distances are only used where they come out positive
        dx_left  = r_ext - x_ext;
        dx_right = x_ext + r_ext + 13'd1 - {1'b0, cfg.box_width};
        dy_top   = r_ext - y_ext;
        dy_bot   = y_ext + r_ext + 13'd1 - {1'b0, cfg.box_height};

        geom.in_box = (cfg.corner_radius != '0) && (xl || xr) && (yt || yb);
        geom.dx     = xl ? dx_left[DIST_W-1:0] : dx_right[DIST_W-1:0];
        geom.dy     = yt ? dy_top[DIST_W-1:0] : dy_bot[DIST_W-1:0];

        geom.inner_mag = (cfg.corner_radius >= cfg.border_width)
                       ? cfg.corner_radius - cfg.border_width
                       : cfg.border_width - cfg.corner_radius;

        // min(x, y, w-1-x, h-1-y) < b, written as four compares
        near_edge = (x_ext < b_ext) || (y_ext < b_ext)
                 || ({1'b0, cfg.box_width} <= (b_ext + x_ext))
                 || ({1'b0, cfg.box_height} <= (b_ext + y_ext));
        geom.band = (cfg.border_width != '0) && near_edge;

        geom.x = x;
        geom.y = y;
    end

endmodule

FILE: rtl/rrps_square_unit.sv
// squared distances, squared radii and the row offset product
// depends on rrps_pkg
module rrps_square_unit import rrps_pkg::*;
(
    input  cfg_regs_t cfg,
    input  geom_t     geom,
    output sq_t       sq
);

    logic [2*DIST_W-1:0]        dx2;
    logic [2*DIST_W-1:0]        dy2;
    logic [PIX_W+PITCH_W-1:0]   prod_full;

    always_comb
    begin
        dx2       = geom.dx * geom.dx;
        dy2       = geom.dy * geom.dy;
        prod_full = geom.y * cfg.row_pitch;

        sq.in_box = geom.in_box;
        sq.band   = geom.band;
        sq.d2     = {1'b0, dx2} + {1'b0, dy2};
        sq.r2     = cfg.corner_radius * cfg.corner_radius;
        sq.inner2 = geom.inner_mag * geom.inner_mag;
        sq.prod   = prod_full[ADDR_W-1:0];
        sq.x      = geom.x;
    end

endmodule

FILE: rtl/rrps_color_pick.sv
// final corner compares, color choice and address sum
// depends on rrps_pkg
module rrps_color_pick import rrps_pkg::*;
(
    input  cfg_regs_t          cfg,
    input  sq_t                sq,
    output logic [COLOR_W-1:0] pixel_value,
    output logic [ADDR_W-1:0]  pixel_addr
);

    logic [COLOR_W-1:0] fill;
    logic               outside;
    logic               on_arc;

    always_comb
    begin
        fill = cfg.pressed_mode ? ((cfg.fill_color & DARKEN_MASK) >> 1) : cfg.fill_color;

        outside = sq.in_box && (sq.d2 > {3'b000, sq.r2});
        on_arc  = sq.in_box && (cfg.border_width != '0) && (sq.d2 > {3'b000, sq.inner2});

        if (outside)
        begin
            pixel_value = TRANSPARENT;
        end
        else if (on_arc || sq.band)
        begin
            pixel_value = cfg.edge_color;
        end
        else
        begin
            pixel_value = fill;
        end

        pixel_addr = sq.prod + {{(ADDR_W-PIX_W){1'b0}}, sq.x};
    end

endmodule

FILE: rtl/rounded_rect_pixel_shader.sv
// Rounded rectangle button pixel shader, top level.
// Channels: pix_in takes one (pix_x, pix_y) beat, pix_out gives one beat with
// pixel_value and pixel_addr for it, cfg writes one register per beat
// (0 box_width, 1 box_height, 2 corner_radius, 3 border_width, 4 fill_color,
// 5 edge_color, 6 pressed_mode, 7 row_pitch). cfg.ready is always high;
// write registers only while no pixel is in flight.
// Pipeline: a pixel accepted into the input register passes through two inner
// stages and the output register before it shows on pix_out.
// Throughput: one pixel per clock while pix_out is not stalled; the squaring
// stage has one multiplier per term, each followed by a register.
// Stall: each stage loads when empty or when the stage after it moves, so
// bubbles close up and pix_in keeps taking beats while pix_out is stalled
// until all four stages are full.
// Reset: all stages empty, registers return to 64 x 32, no radius, no
// border, black colors, not pressed, row_pitch = MAX_DIM.
// Depends on rrps_pkg, rrps_if, rrps_corner_sel, rrps_square_unit,
// rrps_color_pick.
module rounded_rect_pixel_shader import rrps_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    rrps_pix_in_if.sink    pix_in,
    rrps_pix_out_if.source pix_out,
    rrps_cfg_if.sink       cfg
);

    cfg_regs_t cfg_reg;

    logic               v0_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic [PIX_W-1:0]   x_reg;
    logic [PIX_W-1:0]   y_reg;
    geom_t              geom_reg;
    sq_t                sq_reg;
    logic [COLOR_W-1:0] value_reg;
    logic [ADDR_W-1:0]  addr_reg;

    logic               en0;
    logic               en1;
    logic               en2;
    logic               en3;
    geom_t              geom_next;
    sq_t                sq_next;
    logic [COLOR_W-1:0] value_next;
    logic [ADDR_W-1:0]  addr_next;

    // register file
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_width     <= 12'd64;
            cfg_reg.box_height    <= 12'd32;
            cfg_reg.corner_radius <= '0;
            cfg_reg.border_width  <= '0;
            cfg_reg.fill_color    <= '0;
            cfg_reg.edge_color    <= '0;
            cfg_reg.pressed_mode  <= 1'b0;
            cfg_reg.row_pitch     <= PITCH_W'(MAX_DIM);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BOX_WIDTH:     cfg_reg.box_width     <= cfg.data[DIM_W-1:0];
                REG_BOX_HEIGHT:    cfg_reg.box_height    <= cfg.data[DIM_W-1:0];
                REG_CORNER_RADIUS: cfg_reg.corner_radius <= cfg.data[RAD_W-1:0];
                REG_BORDER_WIDTH:  cfg_reg.border_width  <= cfg.data[RAD_W-1:0];
                REG_FILL_COLOR:    cfg_reg.fill_color    <= cfg.data[COLOR_W-1:0];
                REG_EDGE_COLOR:    cfg_reg.edge_color    <= cfg.data[COLOR_W-1:0];
                REG_PRESSED_MODE:  cfg_reg.pressed_mode  <= cfg.data[0];
                REG_ROW_PITCH:     cfg_reg.row_pitch     <= cfg.data[PITCH_W-1:0];
                default:           cfg_reg.row_pitch     <= cfg_reg.row_pitch;
            endcase
        end
    end

    // stage enables, bubbles collapse
    assign en3 = !v3_reg || pix_out.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    assign pix_in.ready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= pix_in.valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    rrps_corner_sel u_corner_sel (
        .cfg  (cfg_reg),
        .x    (x_reg),
        .y    (y_reg),
        .geom (geom_next)
    );

    rrps_square_unit u_square_unit (
        .cfg  (cfg_reg),
        .geom (geom_reg),
        .sq   (sq_next)
    );

    rrps_color_pick u_color_pick (
        .cfg         (cfg_reg),
        .sq          (sq_reg),
        .pixel_value (value_next),
        .pixel_addr  (addr_next)
    );

    always_ff @(posedge clk)
    begin
        if (en0 && pix_in.valid)
        begin
            x_reg <= pix_in.pix_x;
            y_reg <= pix_in.pix_y;
        end
        if (en1 && v0_reg)
        begin
            geom_reg <= geom_next;
        end
        if (en2 && v1_reg)
        begin
            sq_reg <= sq_next;
        end
        if (en3 && v2_reg)
        begin
            value_reg <= value_next;
            addr_reg  <= addr_next;
        end
    end

    assign pix_out.valid       = v3_reg;
    assign pix_out.pixel_value = value_reg;
    assign pix_out.pixel_addr  = addr_reg;

`ifndef NO_ASSERTIONS
    // a full pipeline behind a stalled output must refuse new beats
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && v1_reg && v2_reg && v3_reg && !pix_out.ready) |-> !pix_in.ready)
        else $error("input accepted while every stage is full and output stalled");

    // a result only appears when the squaring stage held an item
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("output valid without an item in the stage before it");

    // corner hits only happen with a nonzero radius
    a_corner_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && geom_reg.in_box) |-> (cfg_reg.corner_radius != '0))
        else $error("corner box flagged with zero radius");

    // an item in flight never vanishes while the output is stalled
    a_hold_items: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !pix_out.ready) |=> v3_reg)
        else $error("stalled result dropped");
`endif

endmodule

FILE: dv/rrps_tb_pkg.sv
// scoreboard for the rounded rectangle pixel shader testbench
// holds a shadow copy of the registers and predicts each pixel beat
// depends on rrps_pkg for widths, register codes and the register struct
package rrps_tb_pkg;
    import rrps_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] value;
        logic [ADDR_W-1:0]  addr;
    } shaded_pixel_t;

    class pixel_scoreboard;
        cfg_regs_t     regs;
        shaded_pixel_t expected_pixels[$];
        int unsigned   errors;

        function new();
            errors = 0;
            regs.box_width     = DIM_W'(64);
            regs.box_height    = DIM_W'(32);
            regs.corner_radius = '0;
            regs.border_width  = '0;
            regs.fill_color    = '0;
            regs.edge_color    = '0;
            regs.pressed_mode  = 1'b0;
            regs.row_pitch     = PITCH_W'(MAX_DIM);
        endfunction

        // high bits beyond each register width drop off here
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BOX_WIDTH:     regs.box_width     = data[DIM_W-1:0];
                REG_BOX_HEIGHT:    regs.box_height    = data[DIM_W-1:0];
                REG_CORNER_RADIUS: regs.corner_radius = data[RAD_W-1:0];
                REG_BORDER_WIDTH:  regs.border_width  = data[RAD_W-1:0];
                REG_FILL_COLOR:    regs.fill_color    = data[COLOR_W-1:0];
                REG_EDGE_COLOR:    regs.edge_color    = data[COLOR_W-1:0];
                REG_PRESSED_MODE:  regs.pressed_mode  = data[0];
                REG_ROW_PITCH:     regs.row_pitch     = data[PITCH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [COLOR_W-1:0] shade(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            longint x, y, w, h, r, b, dx, dy, d2, inner, near;
            bit in_box;
            logic [COLOR_W-1:0] fill;
            x = px;
            y = py;
            w = regs.box_width;
            h = regs.box_height;
            r = regs.corner_radius;
            b = regs.border_width;
            fill = regs.fill_color;
            if (regs.pressed_mode)
                fill = (fill & DARKEN_MASK) >> 1;
            if (r > 0)
            begin
                // first corner box that matches wins when they overlap
                in_box = 1'b1;
                dx = 0;
                dy = 0;
                if (x < r && y < r)
                begin
                    dx = r - x;
                    dy = r - y;
                end
                else if (x >= w - r && y < r)
                begin
                    dx = x - (w - 1 - r);
                    dy = r - y;
                end
                else if (x < r && y >= h - r)
                begin
                    dx = r - x;
                    dy = y - (h - 1 - r);
                end
                else if (x >= w - r && y >= h - r)
                begin
                    dx = x - (w - 1 - r);
                    dy = y - (h - 1 - r);
                end
                else
                    in_box = 1'b0;
                if (in_box && dx >= 0 && dy >= 0)
                begin
                    d2 = dx * dx + dy * dy;
                    inner = r - b;
                    if (d2 > r * r)
                        return TRANSPARENT;
                    if (b > 0 && d2 > inner * inner)
                        return regs.edge_color;
                end
            end
            if (b > 0)
            begin
                // far-edge distances go negative for pixels outside the box
                near = x;
                if (y < near)
                    near = y;
                if (w - 1 - x < near)
                    near = w - 1 - x;
                if (h - 1 - y < near)
                    near = h - 1 - y;
                if (near < b)
                    return regs.edge_color;
            end
            return fill;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            shaded_pixel_t p;
            longint a;
            a = longint'(py) * longint'(regs.row_pitch) + longint'(px);
            p.value = shade(px, py);
            p.addr  = a[ADDR_W-1:0];
            expected_pixels.push_back(p);
        endfunction

        function void check_pixel(logic [COLOR_W-1:0] value, logic [ADDR_W-1:0] addr);
            shaded_pixel_t p;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: pixel beat with none pending: expected nothing, actual value %h addr %h",
                         $time, value, addr);
                return;
            end
            p = expected_pixels.pop_front();
            if (value !== p.value)
            begin
                errors++;
                $display("%0t: pixel_value expected %h actual %h (addr %h)",
                         $time, p.value, value, p.addr);
            end
            if (addr !== p.addr)
            begin
                errors++;
                $display("%0t: pixel_addr expected %h actual %h", $time, p.addr, addr);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

endpackage

FILE: dv/rounded_rect_pixel_shader_tb.sv
// testbench top for the rounded rectangle pixel shader
// directed corner, border and box cases, then random register settings and pixels
// depends on rrps_pkg, rrps_if, the shader rtl and rrps_tb_pkg
module rounded_rect_pixel_shader_tb;
    import rrps_pkg::*;
    import rrps_tb_pkg::*;

    localparam int RANDOM_PIXELS = 950;
    localparam int CYCLE_LIMIT   = 600000;

    logic clk;
    logic rst_n;

    rrps_pix_in_if  pix_in_ch();
    rrps_pix_out_if pix_out_ch();
    rrps_cfg_if     cfg_ch();

    pixel_scoreboard sb = new();

    bit sender_idle   = 1'b0;
    bit receiver_idle = 1'b0;
    bit hold_request  = 1'b0;

    rounded_rect_pixel_shader dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_ch),
        .pix_out (pix_out_ch),
        .cfg     (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned draw_gap(bit idle_on);
        if (!idle_on || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [31:0] with_noise(logic [31:0] v, int width);
        if (width < 32 && $urandom_range(0, 3) == 0)
            return v | ($urandom() << width);
        return v;
    endfunction

    function automatic cfg_regs_t make_cfg(int w, int h, int r, int b, logic [31:0] fill,
                                           logic [31:0] edge_c, bit pressed, int pitch);
        cfg_regs_t c;
        c.box_width     = w[DIM_W-1:0];
        c.box_height    = h[DIM_W-1:0];
        c.corner_radius = r[RAD_W-1:0];
        c.border_width  = b[RAD_W-1:0];
        c.fill_color    = fill;
        c.edge_color    = edge_c;
        c.pressed_mode  = pressed;
        c.row_pitch     = pitch[PITCH_W-1:0];
        return c;
    endfunction

    function automatic int rand_dim();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return $urandom_range(1, 64);
            7:       return $urandom_range(1, 2048);
            8:       return $urandom_range(0, 1) ? 1 : 2048;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic cfg_regs_t rand_cfg();
        int w, h, m, r, b, pitch;
        w = rand_dim();
        h = rand_dim();
        m = (w < h) ? w : h;
        case ($urandom_range(0, 9))
            0:             r = 0;
            1, 2, 3, 4, 5: r = $urandom_range(0, m / 2 + 1);
            6:             r = $urandom_range(0, 1024);
            7:             r = 1024;
            8:             r = $urandom_range(0, 2047);
            default:       r = $urandom_range(1, m + 2);
        endcase
        case ($urandom_range(0, 9))
            0:             b = 0;
            1, 2, 3, 4, 5: b = $urandom_range(0, r + 2);
            6:             b = $urandom_range(0, 1024);
            7:             b = 1024;
            8:             b = $urandom_range(r < 2047 ? r : 2047, 2047);
            default:       b = 1;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: pitch = $urandom_range(1, 4096);
            6:                pitch = 0;
            7:                pitch = 4096;
            8:                pitch = 8191;
            default:          pitch = $urandom_range(0, 8191);
        endcase
        return make_cfg(w, h, r, b, $urandom(), $urandom(), 1'($urandom_range(0, 1)), pitch);
    endfunction

    function automatic int inside_span(int n);
        if (n == 0)
            return $urandom_range(0, 2047);
        return $urandom_range(0, (n > 2048 ? 2048 : n) - 1);
    endfunction

    // lands within the radius plus two pixels from either end of the span
    function automatic int near_corner(int n, int r);
        int span, p;
        span = r + 2;
        if ($urandom_range(0, 1))
            p = int'($urandom_range(0, span));
        else
            p = n - 1 - int'($urandom_range(0, span));
        if (p < 0)
            p = 0;
        if (p > 2047)
            p = 2047;
        return p;
    endfunction

    function automatic void pick_pixel(output logic [PIX_W-1:0] px, output logic [PIX_W-1:0] py);
        int w, h, r, sel, x, y;
        w = sb.regs.box_width;
        h = sb.regs.box_height;
        r = sb.regs.corner_radius;
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            x = inside_span(w);
            y = inside_span(h);
        end
        else if (sel < 85)
        begin
            x = near_corner(w, r);
            y = near_corner(h, r);
        end
        else
        begin
            x = $urandom_range(0, 2047);
            y = $urandom_range(0, 2047);
        end
        px = x[PIX_W-1:0];
        py = y[PIX_W-1:0];
    endfunction

    // valid stays high after the beat so back-to-back beats need no toggle
    task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        int unsigned gap;
        gap = draw_gap(sender_idle);
        @(negedge clk);
        if (gap > 0)
        begin
            pix_in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in_ch.valid = 1'b1;
        pix_in_ch.pix_x = px;
        pix_in_ch.pix_y = py;
        do @(posedge clk); while (!pix_in_ch.ready);
        sb.note_pixel(px, py);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        pix_in_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(cfg_regs_t c);
        write_reg(REG_BOX_WIDTH,     with_noise(c.box_width, DIM_W));
        write_reg(REG_BOX_HEIGHT,    with_noise(c.box_height, DIM_W));
        write_reg(REG_CORNER_RADIUS, with_noise(c.corner_radius, RAD_W));
        write_reg(REG_BORDER_WIDTH,  with_noise(c.border_width, RAD_W));
        write_reg(REG_FILL_COLOR,    c.fill_color);
        write_reg(REG_EDGE_COLOR,    c.edge_color);
        write_reg(REG_PRESSED_MODE,  with_noise(c.pressed_mode, 1));
        write_reg(REG_ROW_PITCH,     with_noise(c.row_pitch, PITCH_W));
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // output side: per-beat stalls plus a long hold-off when asked for
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = $urandom_range(40, 120);
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_out_ch.ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pix_out_ch.ready = 1'b0;
            end
            else
                pix_out_ch.ready = 1'b1;
            @(posedge clk);
            if (pix_out_ch.valid && pix_out_ch.ready)
            begin
                sb.check_pixel(pix_out_ch.pixel_value, pix_out_ch.pixel_addr);
                stall_left = draw_gap(receiver_idle);
            end
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int unsigned sent, phase, phase_items, pause_at, k;
        logic [PIX_W-1:0] px, py;
        rst_n = 1'b0;
        pix_in_ch.valid  = 1'b0;
        pix_in_ch.pix_x  = '0;
        pix_in_ch.pix_y  = '0;
        pix_out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_BOX_WIDTH;
        cfg_ch.data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values
        send_pixel(0, 0);
        send_pixel(63, 31);
        send_pixel(2047, 2047);
        wait_drained();

        // rounded corners with a border, pixels outside the box too
        program_regs(make_cfg(40, 30, 8, 2, 32'h1122_3344, 32'hAABB_CCDD, 1'b0, 100));
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        send_pixel(0, 0);
        send_pixel(7, 1);
        send_pixel(8, 8);
        send_pixel(39, 0);
        send_pixel(0, 29);
        send_pixel(39, 29);
        send_pixel(20, 0);
        send_pixel(20, 15);
        send_pixel(2047, 15);
        send_pixel(15, 2047);
        wait_drained();

        // zero-sized box, pressed fill, widest pitch
        program_regs(make_cfg(0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0, 1'b1, 8191));
        send_pixel(2047, 2047);
        send_pixel(0, 0);
        send_pixel(1, 2047);
        send_pixel(2047, 1);
        send_pixel(11'h555, 11'h2AA);
        wait_drained();

        // overlapping corner boxes, border wider than the radius, zero pitch
        program_regs(make_cfg(10, 12, 20, 30, 32'h0F0F_0F0F, 32'h8000_0001, 1'b0, 0));
        send_pixel(0, 0);
        send_pixel(9, 0);
        send_pixel(0, 11);
        send_pixel(9, 11);
        send_pixel(5, 6);
        send_pixel(2047, 0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS)
        begin
            wait_drained();
            if (phase == 2)
                program_regs(make_cfg(2048, 2048, 1024, 1024, $urandom(), $urandom(),
                                      1'b1, 4096));
            else if (phase == 3)
                program_regs(make_cfg(1, 1, 0, 0, $urandom(), $urandom(), 1'b0, 0));
            else
                program_regs(rand_cfg());
            sender_idle   = $urandom_range(0, 2) != 0;
            receiver_idle = $urandom_range(0, 2) != 0;
            if (phase == 0 || $urandom_range(0, 4) == 0)
            begin
                // back-to-back beats against a stalled output fill the pipe
                sender_idle  = 1'b0;
                hold_request = 1'b1;
            end
            phase_items = $urandom_range(40, 110);
            if (phase_items > RANDOM_PIXELS - sent)
                phase_items = RANDOM_PIXELS - sent;
            pause_at = (phase % 3 == 1) ? $urandom_range(0, phase_items - 1) : phase_items;
            for (k = 0; k < phase_items; k++)
            begin
                if (k == pause_at)
                    wait_drained();
                pick_pixel(px, py);
                send_pixel(px, py);
            end
            sent += phase_items;
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
